// ===== design/psk_pkg.sv =====
// Shared types, codes and the key layout table of the PS/2 set-1 keyboard decoder.
package psk_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;

    // input operations
    localparam logic OP_RX    = 1'b0;
    localparam logic OP_START = 1'b1;

    // configuration register indexes
    localparam logic CFG_INIT_LOCK = 1'b0;
    localparam logic CFG_LED_CMD   = 1'b1;

    localparam logic [7:0] LED_CMD_RESET = 8'd237;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_BKSP  = 2'd1;
    localparam logic [1:0] KIND_FOCUS = 2'd2;
    localparam logic [1:0] KIND_SEND  = 2'd3;

    // scan codes with a meaning of their own
    localparam logic [7:0] SC_BKSP       = 8'h0e;
    localparam logic [7:0] SC_TAB        = 8'h0f;
    localparam logic [7:0] SC_LSHIFT     = 8'h2a;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hb6;
    localparam logic [7:0] SC_CAPS       = 8'h3a;
    localparam logic [7:0] SC_NUM        = 8'h45;
    localparam logic [7:0] SC_SCROLL     = 8'h46;
    localparam logic [7:0] SC_ACK        = 8'hfa;
    localparam logic [7:0] SC_RESEND     = 8'hfe;

    // lock bit masks
    localparam logic [2:0] LOCK_SCROLL = 3'b001;
    localparam logic [2:0] LOCK_NUM    = 3'b010;
    localparam logic [2:0] LOCK_CAPS   = 3'b100;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_BKSP    = 8'h08;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       pop;
    } psk_qctl_t;

    typedef struct packed {
        logic       head_valid;
        logic [7:0] head_data;
        logic       empty;
        logic       full;
    } psk_qstat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       focus;
        logic       last;
    } psk_result_t;

    // Japanese layout, make codes below 0x80; zero means no character
    function automatic logic [7:0] map_key(input logic [6:0] idx, input logic shifted);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            7'h02: ch = shifted ? 8'h21 : 8'h31;
            7'h03: ch = shifted ? 8'h22 : 8'h32;
            7'h04: ch = shifted ? 8'h23 : 8'h33;
            7'h05: ch = shifted ? 8'h24 : 8'h34;
            7'h06: ch = shifted ? 8'h25 : 8'h35;
            7'h07: ch = shifted ? 8'h26 : 8'h36;
            7'h08: ch = shifted ? 8'h27 : 8'h37;
            7'h09: ch = shifted ? 8'h28 : 8'h38;
            7'h0a: ch = shifted ? 8'h29 : 8'h39;
            7'h0b: ch = shifted ? 8'h7e : 8'h30;
            7'h0c: ch = shifted ? 8'h3d : 8'h2d;
            7'h0d: ch = shifted ? 8'h7e : 8'h5e;
            7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;
            7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;
            7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;
            7'h17: ch = 8'h49;
            7'h18: ch = 8'h4f;
            7'h19: ch = 8'h50;
            7'h1a: ch = shifted ? 8'h60 : 8'h40;
            7'h1b: ch = shifted ? 8'h7b : 8'h5b;
            7'h1e: ch = 8'h41;
            7'h1f: ch = 8'h53;
            7'h20: ch = 8'h44;
            7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;
            7'h24: ch = 8'h4a;
            7'h25: ch = 8'h4b;
            7'h26: ch = 8'h4c;
            7'h27: ch = shifted ? 8'h2b : 8'h3b;
            7'h28: ch = shifted ? 8'h2a : 8'h3a;
            7'h2b: ch = shifted ? 8'h7d : 8'h5d;
            7'h2c: ch = 8'h5a;
            7'h2d: ch = 8'h58;
            7'h2e: ch = 8'h43;
            7'h2f: ch = 8'h56;
            7'h30: ch = 8'h42;
            7'h31: ch = 8'h4e;
            7'h32: ch = 8'h4d;
            7'h33: ch = shifted ? 8'h3c : 8'h2c;
            7'h34: ch = shifted ? 8'h3e : 8'h2e;
            7'h35: ch = shifted ? 8'h3f : 8'h2f;
            7'h37: ch = 8'h2a;
            7'h39: ch = 8'h20;
            7'h47: ch = 8'h37;
            7'h48: ch = 8'h38;
            7'h49: ch = 8'h39;
            7'h4a: ch = 8'h2d;
            7'h4b: ch = 8'h34;
            7'h4c: ch = 8'h35;
            7'h4d: ch = 8'h36;
            7'h4e: ch = 8'h2b;
            7'h4f: ch = 8'h31;
            7'h50: ch = 8'h32;
            7'h51: ch = 8'h33;
            7'h52: ch = 8'h30;
            7'h53: ch = 8'h2e;
            7'h73: ch = shifted ? 8'h5f : 8'h5c;
            7'h7d: ch = shifted ? 8'h7c : 8'h5c;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/psk_ram.sv =====
// Generic single-port-write, registered-read RAM.
module psk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = psk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/psk_cmdq.sv =====
// Keyboard command byte queue: RAM body with a head register in front.
module psk_cmdq #(
    parameter int DEPTH = psk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  psk_pkg::psk_qctl_t     ctl,
    output psk_pkg::psk_qstat_t    stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] ram_cnt_reg, ram_cnt_next;
    logic [CW-1:0] count_reg, count_next;
    logic          hq_valid_reg, hq_valid_next;
    logic [7:0]    hq_data_reg, hq_data_next;
    logic          rd_busy_reg, rd_busy_next;

    logic          hq_free;
    logic          bypass;
    logic          ram_we;
    logic          rd_issue;
    logic [7:0]    ram_rdata;

    // head slot frees up when empty or popped this cycle
    assign hq_free  = !hq_valid_reg || ctl.pop;
    // nothing ahead of the pushed byte: drop it straight into the head slot
    assign bypass   = ctl.push && hq_free && (ram_cnt_reg == '0) && !rd_busy_reg;
    assign ram_we   = ctl.push && !bypass;
    assign rd_issue = (ram_cnt_reg != '0) && !rd_busy_reg && hq_free;

    psk_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ctl.data),
        .re    (rd_issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        hq_valid_next = hq_valid_reg;
        hq_data_next  = hq_data_reg;
        rd_busy_next  = rd_issue;
        ram_cnt_next  = ram_cnt_reg + CW'(ram_we) - CW'(rd_issue);
        count_next    = count_reg + CW'(ctl.push) - CW'(ctl.pop);

        if (ram_we)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (rd_issue)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end

        if (rd_busy_reg)
        begin
            hq_valid_next = 1'b1;
            hq_data_next  = ram_rdata;
        end
        else if (bypass)
        begin
            hq_valid_next = 1'b1;
            hq_data_next  = ctl.data;
        end
        else if (ctl.pop)
        begin
            hq_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            ram_cnt_reg  <= '0;
            count_reg    <= '0;
            hq_valid_reg <= 1'b0;
            hq_data_reg  <= 8'h00;
            rd_busy_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            ram_cnt_reg  <= ram_cnt_next;
            count_reg    <= count_next;
            hq_valid_reg <= hq_valid_next;
            hq_data_reg  <= hq_data_next;
            rd_busy_reg  <= rd_busy_next;
        end
    end

    assign stat.head_valid = hq_valid_reg;
    assign stat.head_data  = hq_data_reg;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(DEPTH));

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> hq_valid_reg)
        else $error("pop without a head byte");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !stat.full)
        else $error("push into a full queue");

    a_land_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_busy_reg |-> !hq_valid_reg)
        else $error("RAM read lands on an occupied head slot");

endmodule

// ===== design/ps2_scancode_keyboard_decoder_unit.sv =====
// Top level of the PS/2 set-1 scan code decoder with LED command queue.
// Path from input transfer to the first result transfer: input register, decode state,
//   then the finish state that loads the result buffer.
// Decode of the next item waits for the finish of the previous one; a finish waits while
//   a result stays in the buffer or the queue head is still coming out of the RAM.
// Reset: asynchronous, active low; clears keys, locks, focus and queue. No clearing pass.
module ps2_scancode_keyboard_decoder_unit #(
    parameter int QUEUE_DEPTH = psk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // item channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] scan_code,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic       focus_target,
    output logic       last,
    // configuration writes
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    typedef enum logic {
        ST_DECODE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [2:0] init_lock_reg, init_lock_next;
    logic [7:0] led_cmd_reg, led_cmd_next;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       in_opcode_reg, in_opcode_next;
    logic [7:0] in_scan_reg, in_scan_next;

    // keyboard state
    logic [1:0] shift_reg, shift_next;
    logic [2:0] lock_reg, lock_next;
    logic       focus_reg, focus_next;
    logic       awaiting_reg, awaiting_next;
    logic [7:0] pending_reg, pending_next;

    // what decode hands to finish
    logic       ev_valid_reg, ev_valid_next;
    logic [1:0] ev_kind_reg, ev_kind_next;
    logic [7:0] ev_value_reg, ev_value_next;
    logic       push2_reg, push2_next;
    logic [2:0] push2_data_reg, push2_data_next;

    // result buffer, slot 0 is presented
    psk_pkg::psk_result_t ob_reg [2];
    psk_pkg::psk_result_t ob_next [2];
    logic [1:0] ob_cnt_reg, ob_cnt_next;

    psk_pkg::psk_qctl_t  qctl;
    psk_pkg::psk_qstat_t qstat;

    logic       in_accept;
    logic       in_take;
    logic       out_transfer;
    logic       send;
    logic       ob_room;
    logic       fin;
    logic       push_cmd;
    logic [7:0] raw_char;
    logic [7:0] key_char;
    psk_pkg::psk_result_t res_ev;
    psk_pkg::psk_result_t res_send;

    psk_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (qctl),
        .stat  (qstat)
    );

    // Hold the input register while the previous item is still finishing.
    assign in_take      = (state_reg == ST_DECODE) && in_valid_reg;
    assign in_stall     = in_valid_reg && !in_take;
    assign in_accept    = in_valid && !in_stall;

    assign out_valid    = (ob_cnt_reg != 2'd0);
    assign out_transfer = out_valid && !out_stall;

    // Send the queue head when bytes wait and no acknowledge is owed. The lock byte of
    // this item is only pushed behind its command byte, so the queue is never empty then.
    assign send    = !qstat.empty && !awaiting_reg;
    // Finish only into a buffer that is empty or drains this cycle.
    assign ob_room = (ob_cnt_reg == 2'd0) || ((ob_cnt_reg == 2'd1) && out_transfer);
    assign fin     = (state_reg == ST_FINISH) && ob_room && (!send || qstat.head_valid);

    // Layout lookup, then fold to lower case when caps lock and shift agree.
    assign raw_char = in_scan_reg[7] ? 8'h00
                    : psk_pkg::map_key(in_scan_reg[6:0], shift_reg != 2'b00);

    always_comb
    begin
        key_char = raw_char;
        if ((raw_char >= psk_pkg::CHAR_UPPER_A) && (raw_char <= psk_pkg::CHAR_UPPER_Z)
            && (((lock_reg & psk_pkg::LOCK_CAPS) != 3'b000) == (shift_reg != 2'b00)))
        begin
            key_char = raw_char + psk_pkg::CASE_OFFSET;
        end
    end

    always_comb
    begin
        res_ev.kind    = ev_kind_reg;
        res_ev.value   = ev_value_reg;
        res_ev.focus   = focus_reg;
        res_ev.last    = !send;
        res_send.kind  = psk_pkg::KIND_SEND;
        res_send.value = qstat.head_data;
        res_send.focus = focus_reg;
        res_send.last  = 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        init_lock_next  = init_lock_reg;
        led_cmd_next    = led_cmd_reg;
        in_valid_next   = in_valid_reg;
        in_opcode_next  = in_opcode_reg;
        in_scan_next    = in_scan_reg;
        shift_next      = shift_reg;
        lock_next       = lock_reg;
        focus_next      = focus_reg;
        awaiting_next   = awaiting_reg;
        pending_next    = pending_reg;
        ev_valid_next   = ev_valid_reg;
        ev_kind_next    = ev_kind_reg;
        ev_value_next   = ev_value_reg;
        push2_next      = push2_reg;
        push2_data_next = push2_data_reg;
        ob_next         = ob_reg;
        ob_cnt_next     = ob_cnt_reg;
        push_cmd        = 1'b0;
        qctl.push       = 1'b0;
        qctl.data       = led_cmd_reg;
        qctl.pop        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                psk_pkg::CFG_INIT_LOCK: init_lock_next = cfg_data[2:0];
                psk_pkg::CFG_LED_CMD:   led_cmd_next   = cfg_data;
                default: ;
            endcase
        end

        // input register: load on transfer, drop once decode takes it
        if (in_accept)
        begin
            in_valid_next  = 1'b1;
            in_opcode_next = opcode;
            in_scan_next   = scan_code;
        end
        else if (in_take)
        begin
            in_valid_next = 1'b0;
        end

        // Decode: update key state, record the event, push the command byte.
        if (in_take)
        begin
            state_next    = ST_FINISH;
            ev_valid_next = 1'b0;
            ev_kind_next  = psk_pkg::KIND_CHAR;
            ev_value_next = 8'h00;
            push2_next    = 1'b0;
            if (in_opcode_reg == psk_pkg::OP_START)
            begin
                lock_next  = init_lock_reg;
                push_cmd   = 1'b1;
                push2_next = 1'b1;
            end
            else
            begin
                if (key_char != 8'h00)
                begin
                    ev_valid_next = 1'b1;
                    ev_value_next = key_char;
                end
                case (in_scan_reg)
                    psk_pkg::SC_BKSP:
                    begin
                        ev_valid_next = 1'b1;
                        ev_kind_next  = psk_pkg::KIND_BKSP;
                        ev_value_next = psk_pkg::CHAR_BKSP;
                    end
                    psk_pkg::SC_TAB:
                    begin
                        focus_next    = !focus_reg;
                        ev_valid_next = 1'b1;
                        ev_kind_next  = psk_pkg::KIND_FOCUS;
                        ev_value_next = {7'b0000000, !focus_reg};
                    end
                    psk_pkg::SC_LSHIFT:     shift_next = shift_reg | 2'b01;
                    psk_pkg::SC_RSHIFT:     shift_next = shift_reg | 2'b10;
                    psk_pkg::SC_LSHIFT_BRK: shift_next = shift_reg & 2'b10;
                    psk_pkg::SC_RSHIFT_BRK: shift_next = shift_reg & 2'b01;
                    psk_pkg::SC_CAPS:
                    begin
                        lock_next  = lock_reg ^ psk_pkg::LOCK_CAPS;
                        push_cmd   = 1'b1;
                        push2_next = 1'b1;
                    end
                    psk_pkg::SC_NUM:
                    begin
                        lock_next  = lock_reg ^ psk_pkg::LOCK_NUM;
                        push_cmd   = 1'b1;
                        push2_next = 1'b1;
                    end
                    psk_pkg::SC_SCROLL:
                    begin
                        lock_next  = lock_reg ^ psk_pkg::LOCK_SCROLL;
                        push_cmd   = 1'b1;
                        push2_next = 1'b1;
                    end
                    psk_pkg::SC_ACK:
                    begin
                        awaiting_next = 1'b0;
                    end
                    psk_pkg::SC_RESEND:
                    begin
                        // repeat the last byte only while its acknowledge is owed
                        if (awaiting_reg)
                        begin
                            ev_valid_next = 1'b1;
                            ev_kind_next  = psk_pkg::KIND_SEND;
                            ev_value_next = pending_reg;
                        end
                    end
                    default: ;
                endcase
            end
            push2_data_next = lock_next;
            // a full queue drops the byte; the lock bits toggle anyway
            qctl.push = push_cmd && !qstat.full;
            qctl.data = led_cmd_reg;
        end

        // result buffer drains one slot per transfer
        if (out_transfer)
        begin
            ob_next[0]  = ob_reg[1];
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end

        // Finish: push the lock byte, pop and send the head, load the results.
        if (fin)
        begin
            state_next = ST_DECODE;
            qctl.push  = push2_reg && !qstat.full;
            qctl.data  = {5'b00000, push2_data_reg};
            qctl.pop   = send;
            if (send)
            begin
                pending_next  = qstat.head_data;
                awaiting_next = 1'b1;
            end
            ob_cnt_next = 2'(ev_valid_reg) + 2'(send);
            ob_next[0]  = ev_valid_reg ? res_ev : res_send;
            ob_next[1]  = res_send;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_DECODE;
            init_lock_reg  <= 3'b000;
            led_cmd_reg    <= psk_pkg::LED_CMD_RESET;
            in_valid_reg   <= 1'b0;
            in_opcode_reg  <= psk_pkg::OP_RX;
            in_scan_reg    <= 8'h00;
            shift_reg      <= 2'b00;
            lock_reg       <= 3'b000;
            focus_reg      <= 1'b0;
            awaiting_reg   <= 1'b0;
            pending_reg    <= 8'h00;
            ev_valid_reg   <= 1'b0;
            ev_kind_reg    <= psk_pkg::KIND_CHAR;
            ev_value_reg   <= 8'h00;
            push2_reg      <= 1'b0;
            push2_data_reg <= 3'b000;
            ob_reg[0]      <= '0;
            ob_reg[1]      <= '0;
            ob_cnt_reg     <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            init_lock_reg  <= init_lock_next;
            led_cmd_reg    <= led_cmd_next;
            in_valid_reg   <= in_valid_next;
            in_opcode_reg  <= in_opcode_next;
            in_scan_reg    <= in_scan_next;
            shift_reg      <= shift_next;
            lock_reg       <= lock_next;
            focus_reg      <= focus_next;
            awaiting_reg   <= awaiting_next;
            pending_reg    <= pending_next;
            ev_valid_reg   <= ev_valid_next;
            ev_kind_reg    <= ev_kind_next;
            ev_value_reg   <= ev_value_next;
            push2_reg      <= push2_next;
            push2_data_reg <= push2_data_next;
            ob_reg[0]      <= ob_next[0];
            ob_reg[1]      <= ob_next[1];
            ob_cnt_reg     <= ob_cnt_next;
        end
    end

    assign kind         = ob_reg[0].kind;
    assign value        = ob_reg[0].value;
    assign focus_target = ob_reg[0].focus;
    assign last         = ob_reg[0].last;

    a_send_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && send) |=> awaiting_reg)
        else $error("byte sent without waiting for its acknowledge");

    a_two_slot_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ob_cnt_reg == 2'd2) |-> (!ob_reg[0].last && ob_reg[1].last))
        else $error("last flag misplaced in a two-result group");

    a_wait_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(awaiting_reg) |-> out_valid)
        else $error("acknowledge owed but no sent byte buffered");

endmodule
